/* design/iiw_pkg.sv */
// shared types and constants for the instruction issue window
`default_nettype none

package iiw_pkg;

  localparam int DEF_ENTRIES  = 256;
  localparam int DEF_POS_BITS = 16;

  localparam int MODE_W     = 2;
  localparam int WSIZE_W    = 9;
  localparam int IWIDTH_W   = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ISSUE_WIDTH = 1'd1;

  localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ISSUE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK     = 2'd3;

  localparam logic [IWIDTH_W-1:0] ISSUE_CNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_ISSUE,
    OP_COMPLETE,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e  op;
    logic ldp;
  } ctl_t;

endpackage

`default_nettype wire

/* design/iiw_front.sv */
// front end: takes input words, decodes the request and queues them for the back end
`default_nettype none

module iiw_front #(
  parameter int POS_BITS = iiw_pkg::DEF_POS_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [iiw_pkg::MODE_W-1:0] mode_i,
  input  wire logic [POS_BITS-1:0]       position_i,
  input  wire logic                      is_load_produce_i,
  output logic                           q_valid_o,
  input  wire logic                      q_pop_i,
  output iiw_pkg::ctl_t                  q_ctl_o,
  output logic [POS_BITS-1:0]            q_pos_o
);

  localparam int QDEPTH = 2;

  iiw_pkg::ctl_t       ctl_q [QDEPTH];
  logic [POS_BITS-1:0] pos_q [QDEPTH];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          cnt_q, cnt_d;
  iiw_pkg::ctl_t       in_ctl;
  logic                push;
  logic                pop;

  always_comb begin
    in_ctl.ldp = is_load_produce_i;
    case (mode_i)
      iiw_pkg::MODE_INSERT:   in_ctl.op = iiw_pkg::OP_INSERT;
      iiw_pkg::MODE_ISSUE:    in_ctl.op = iiw_pkg::OP_ISSUE;
      iiw_pkg::MODE_COMPLETE: in_ctl.op = iiw_pkg::OP_COMPLETE;
      iiw_pkg::MODE_TICK:     in_ctl.op = iiw_pkg::OP_TICK;
      default:                in_ctl.op = iiw_pkg::OP_TICK;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'(QDEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_ctl_o    = ctl_q[rd_ptr_q];
  assign q_pos_o    = pos_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_q[wr_ptr_q] <= in_ctl;
      pos_q[wr_ptr_q] <= position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* design/iiw_back.sv */
// back end: entry flag store, issue and complete checks, head retirement walk, result register
`default_nettype none

module iiw_back #(
  parameter int ENTRIES  = iiw_pkg::DEF_ENTRIES,
  parameter int POS_BITS = iiw_pkg::DEF_POS_BITS,
  parameter int SLOT_W   = $clog2(ENTRIES),
  parameter int HELD_W   = $clog2(ENTRIES + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [iiw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [iiw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          q_valid_i,
  output logic                               q_pop_o,
  input  wire iiw_pkg::ctl_t                 q_ctl_i,
  input  wire logic [POS_BITS-1:0]           q_pos_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               accepted_o,
  output logic [POS_BITS-1:0]                assigned_position_o,
  output logic [HELD_W-1:0]                  retired_count_o,
  output logic [HELD_W-1:0]                  occupancy_o
);

  localparam int OFF_W = (POS_BITS > HELD_W) ? POS_BITS : HELD_W;
  localparam int CMP_W = (POS_BITS > iiw_pkg::WSIZE_W) ? POS_BITS : iiw_pkg::WSIZE_W;
  localparam logic [SLOT_W:0]   ENT_S = (SLOT_W + 1)'(ENTRIES);
  localparam logic [HELD_W-1:0] ENT_H = HELD_W'(ENTRIES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_FIN
  } state_e;

  // flag store, one bit array per flag so each write touches one address
  logic ldp_mem  [ENTRIES];
  logic iss_mem  [ENTRIES];
  logic done_mem [ENTRIES];
  logic rd_ldp_q, rd_iss_q, rd_done_q;

  logic [iiw_pkg::WSIZE_W-1:0]  wsize_q;
  logic [iiw_pkg::IWIDTH_W-1:0] iwidth_q;

  state_e                       state_q, state_d;
  logic [SLOT_W-1:0]            head_slot_q, head_slot_d;
  logic [POS_BITS-1:0]          head_pos_q, head_pos_d;
  logic [POS_BITS-1:0]          next_pos_q, next_pos_d;
  logic [HELD_W-1:0]            held_q, held_d;
  logic [iiw_pkg::IWIDTH_W-1:0] icnt_q, icnt_d;
  logic [HELD_W-1:0]            ret_q, ret_d;
  logic                         out_valid_q, out_valid_d;
  logic                         acc_q, acc_d;
  logic [POS_BITS-1:0]          asg_q, asg_d;
  logic [HELD_W-1:0]            oret_q, oret_d;
  logic [HELD_W-1:0]            occ_q, occ_d;

  logic [POS_BITS-1:0] off;
  logic [OFF_W-1:0]    off_x;
  logic                hit;
  logic                in_window;
  logic                under_width;
  logic                issue_ok;
  logic [SLOT_W:0]     tgt_sum, ins_sum;
  logic [SLOT_W-1:0]   tgt_slot, ins_slot;
  logic                out_free;
  logic                go;

  logic              wr_all, wr_iss, wr_done;
  logic [SLOT_W-1:0] wr_addr;

  // window always starts at the head, so one offset serves both tests
  assign off         = q_pos_i - head_pos_q;
  assign off_x       = OFF_W'(off);
  assign hit         = off_x < OFF_W'(held_q);
  assign in_window   = (wsize_q == '0) || (CMP_W'(off) < CMP_W'(wsize_q));
  assign under_width = (iwidth_q == '0) || (icnt_q < iwidth_q);
  assign issue_ok    = hit && in_window && under_width;

  assign tgt_sum  = {1'b0, head_slot_q} + {1'b0, off_x[SLOT_W-1:0]};
  assign tgt_slot = (tgt_sum >= ENT_S) ? SLOT_W'(tgt_sum - ENT_S) : tgt_sum[SLOT_W-1:0];
  assign ins_sum  = {1'b0, head_slot_q} + {1'b0, held_q[SLOT_W-1:0]};
  assign ins_slot = (ins_sum >= ENT_S) ? SLOT_W'(ins_sum - ENT_S) : ins_sum[SLOT_W-1:0];

  assign out_free = !out_valid_q || out_ready_i;
  assign go       = rd_done_q || (rd_ldp_q && rd_iss_q);

  always_comb begin
    state_d     = state_q;
    head_slot_d = head_slot_q;
    head_pos_d  = head_pos_q;
    next_pos_d  = next_pos_q;
    held_d      = held_q;
    icnt_d      = icnt_q;
    ret_d       = ret_q;
    out_valid_d = out_valid_q && !out_ready_i;
    acc_d       = acc_q;
    asg_d       = asg_q;
    oret_d      = oret_q;
    occ_d       = occ_q;
    q_pop_o     = 1'b0;
    wr_all      = 1'b0;
    wr_iss      = 1'b0;
    wr_done     = 1'b0;
    wr_addr     = tgt_slot;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_ctl_i.op)
            iiw_pkg::OP_INSERT: begin
              out_valid_d = 1'b1;
              oret_d      = '0;
              if (held_q != ENT_H) begin
                wr_all     = 1'b1;
                wr_addr    = ins_slot;
                acc_d      = 1'b1;
                asg_d      = next_pos_q;
                next_pos_d = next_pos_q + 1'b1;
                held_d     = held_q + 1'b1;
                occ_d      = held_q + 1'b1;
              end else begin
                acc_d = 1'b0;
                asg_d = '0;
                occ_d = held_q;
              end
            end
            iiw_pkg::OP_ISSUE: begin
              out_valid_d = 1'b1;
              acc_d       = issue_ok;
              asg_d       = '0;
              oret_d      = '0;
              occ_d       = held_q;
              if (issue_ok) begin
                wr_iss = 1'b1;
                if (icnt_q != iiw_pkg::ISSUE_CNT_MAX) begin
                  icnt_d = icnt_q + 1'b1;
                end
              end
            end
            iiw_pkg::OP_COMPLETE: begin
              out_valid_d = 1'b1;
              acc_d       = 1'b1;
              asg_d       = '0;
              oret_d      = '0;
              occ_d       = held_q;
              wr_done     = hit;
            end
            iiw_pkg::OP_TICK: begin
              icnt_d  = '0;
              ret_d   = '0;
              state_d = (held_q != '0) ? S_RD : S_FIN;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RD: begin
        // head flags land in the read register at this edge
        state_d = S_CHK;
      end
      S_CHK: begin
        if (go) begin
          head_slot_d = (head_slot_q == LAST_SLOT) ? '0 : head_slot_q + 1'b1;
          head_pos_d  = head_pos_q + 1'b1;
          held_d      = held_q - 1'b1;
          ret_d       = ret_q + 1'b1;
          state_d     = (held_q == HELD_W'(1)) ? S_FIN : S_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          acc_d       = 1'b1;
          asg_d       = '0;
          oret_d      = ret_q;
          occ_d       = held_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_all) begin
      ldp_mem[wr_addr] <= q_ctl_i.ldp;
    end
    if (wr_all || wr_iss) begin
      iss_mem[wr_addr] <= wr_iss;
    end
    if (wr_all || wr_done) begin
      done_mem[wr_addr] <= wr_done;
    end
    rd_ldp_q  <= ldp_mem[head_slot_q];
    rd_iss_q  <= iss_mem[head_slot_q];
    rd_done_q <= done_mem[head_slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q  <= '0;
      iwidth_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        iiw_pkg::CFG_WINDOW_SIZE: wsize_q  <= cfg_data_i;
        iiw_pkg::CFG_ISSUE_WIDTH: iwidth_q <= cfg_data_i[iiw_pkg::IWIDTH_W-1:0];
        default: begin
          wsize_q <= wsize_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_slot_q <= '0;
      head_pos_q  <= '0;
      next_pos_q  <= '0;
      held_q      <= '0;
      icnt_q      <= '0;
      ret_q       <= '0;
      out_valid_q <= 1'b0;
      acc_q       <= 1'b0;
      asg_q       <= '0;
      oret_q      <= '0;
      occ_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_slot_q <= head_slot_d;
      head_pos_q  <= head_pos_d;
      next_pos_q  <= next_pos_d;
      held_q      <= held_d;
      icnt_q      <= icnt_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      asg_q       <= asg_d;
      oret_q      <= oret_d;
      occ_q       <= occ_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign accepted_o          = acc_q;
  assign assigned_position_o = asg_q;
  assign retired_count_o     = oret_q;
  assign occupancy_o         = occ_q;

endmodule

`default_nettype wire

/* design/instruction_issue_window.sv */
// instruction issue window: in-order store of in-flight entries with issue window and retirement
//
// input channel (in_valid_i / in_ready_o) carries one request word: insert, issue request,
// mark complete or tick. every word gives exactly one result word on the output channel
// (out_valid_o / out_ready_i). configuration (window size, issue width) is written through
// cfg_we_i / cfg_index_i / cfg_data_i; the user must write it only while the block is idle,
// and the block itself does not enforce this. a two-word queue sits between the front end
// and the back end, so the input keeps taking words while a result waits to be taken.
// insert, issue and complete are handled by the back end as they leave the queue, one word
// per cycle when the output is drained and no tick walk is running. a tick walks the store
// from the head one entry at a time, stopping when the store is empty or at an entry that
// cannot retire yet, and then presents its result; each entry of the walk takes one read of
// the flag memory (registered read data, then the retire decision).
// reset clears positions, occupancy, issue count, configuration and both handshakes; the
// flag memory is not cleared, every entry is written by insert before it is read.
// when the receiver stalls the result register holds its word; the back end then stops and
// the queue fills, after which in_ready_o drops.
`default_nettype none

module instruction_issue_window #(
  parameter int ENTRIES  = iiw_pkg::DEF_ENTRIES,
  parameter int POS_BITS = iiw_pkg::DEF_POS_BITS,
  parameter int HELD_W   = $clog2(ENTRIES + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [iiw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [iiw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [iiw_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [POS_BITS-1:0]            position_i,
  input  wire logic                           is_load_produce_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                accepted_o,
  output logic [POS_BITS-1:0]                 assigned_position_o,
  output logic [HELD_W-1:0]                   retired_count_o,
  output logic [HELD_W-1:0]                   occupancy_o
);

  logic                q_valid;
  logic                q_pop;
  iiw_pkg::ctl_t       q_ctl;
  logic [POS_BITS-1:0] q_pos;

  iiw_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .position_i        (position_i),
    .is_load_produce_i (is_load_produce_i),
    .q_valid_o         (q_valid),
    .q_pop_i           (q_pop),
    .q_ctl_o           (q_ctl),
    .q_pos_o           (q_pos)
  );

  iiw_back #(
    .ENTRIES  (ENTRIES),
    .POS_BITS (POS_BITS),
    .SLOT_W   ($clog2(ENTRIES)),
    .HELD_W   (HELD_W)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .q_valid_i           (q_valid),
    .q_pop_o             (q_pop),
    .q_ctl_i             (q_ctl),
    .q_pos_i             (q_pos),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .accepted_o          (accepted_o),
    .assigned_position_o (assigned_position_o),
    .retired_count_o     (retired_count_o),
    .occupancy_o         (occupancy_o)
  );

endmodule

`default_nettype wire
